// File: rtl/tlws_pkg.sv
// Shared word types for the text line and word statistics block.
`timescale 1ns / 1ps

package tlws_pkg;

  // Count width used by the line, word, byte and length counters and every result field
  localparam int unsigned CNT_W = 32;

  // Register indexes on the configuration port
  localparam logic CFG_TAB_EXPAND = 1'b0;
  localparam logic CFG_TAB_WIDTH  = 1'b1;

  // Input word: one byte of text plus its markers
  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_present;
    logic       end_of_file;
  } in_word_t;

  // Result word: per-file statistics
  typedef struct packed {
    logic [CNT_W-1:0] line_total;
    logic [CNT_W-1:0] word_total;
    logic [CNT_W-1:0] byte_total;
    logic [CNT_W-1:0] shortest_length;
    logic [CNT_W-1:0] shortest_line_number;
    logic [CNT_W-1:0] longest_length;
    logic [CNT_W-1:0] longest_line_number;
  } out_word_t;

endpackage

// File: rtl/tlws_stats.sv
// Running per-file statistics: counter state and the combinational update.
`timescale 1ns / 1ps

module tlws_stats (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               upd_en,
  input  tlws_pkg::in_word_t item,
  input  logic               tab_expand_en,
  input  logic [4:0]         tab_width,
  output tlws_pkg::out_word_t result
);

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [4:0] STOP_MIN = 5'd1;
  localparam logic [4:0] STOP_MAX = 5'd16;
  localparam int unsigned W = tlws_pkg::CNT_W;
  localparam logic [W-1:0] CNT_MAX = {W{1'b1}};

  // saturating add of two counts
  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[W] ? CNT_MAX : sum[W-1:0];
  endfunction

  logic [W-1:0] line_r, line_nxt;
  logic [W-1:0] word_r, word_nxt;
  logic [W-1:0] byte_r, byte_nxt;
  logic [W-1:0] len_r, len_nxt;
  logic [3:0]   col_r, col_nxt;
  logic         inw_r, inw_nxt;
  logic         open_r, open_nxt;
  logic [W-1:0] min_len_r, min_len_nxt;
  logic [W-1:0] min_idx_r, min_idx_nxt;
  logic [W-1:0] max_len_r, max_len_nxt;
  logic [W-1:0] max_idx_r, max_idx_nxt;

  logic [4:0]   stop_w;
  logic [4:0]   col_cur;
  logic [4:0]   col_inc;
  logic [4:0]   tab_adv;
  logic         present;
  logic         blank;
  logic         newline;
  logic         do_close;
  logic [W-1:0] close_len;
  logic [W-1:0] line_inc;

  // next state for one byte, then closing a line where one ends
  always_comb begin
    stop_w = tab_width;
    if (stop_w < STOP_MIN) begin
      stop_w = STOP_MIN;
    end else if (stop_w > STOP_MAX) begin
      stop_w = STOP_MAX;
    end
    col_cur = {1'b0, col_r};
    if (col_cur >= stop_w) begin
      col_cur = '0;
    end
    col_inc = col_cur + 5'd1;
    tab_adv = stop_w - col_cur;

    present = item.byte_present;
    blank   = (item.text_byte == CH_SPACE) ||
              ((item.text_byte >= CH_TAB) && (item.text_byte <= CH_CR));
    newline = present && (item.text_byte == CH_NL);

    line_nxt    = line_r;
    word_nxt    = word_r;
    byte_nxt    = byte_r;
    len_nxt     = len_r;
    col_nxt     = col_r;
    inw_nxt     = inw_r;
    open_nxt    = open_r;
    min_len_nxt = min_len_r;
    min_idx_nxt = min_idx_r;
    max_len_nxt = max_len_r;
    max_idx_nxt = max_idx_r;

    // byte and word counts
    if (present) begin
      byte_nxt = sat_add(byte_r, {{(W-1){1'b0}}, 1'b1});
      if (blank) begin
        inw_nxt = 1'b0;
      end else if (!inw_r) begin
        inw_nxt  = 1'b1;
        word_nxt = sat_add(word_r, {{(W-1){1'b0}}, 1'b1});
      end
    end

    // line length, with optional tab expansion
    if (present && !newline) begin
      open_nxt = 1'b1;
      if (tab_expand_en && (item.text_byte == CH_TAB)) begin
        len_nxt = sat_add(len_r, {{(W-5){1'b0}}, tab_adv});
        col_nxt = '0;
      end else begin
        len_nxt = sat_add(len_r, {{(W-1){1'b0}}, 1'b1});
        col_nxt = (col_inc >= stop_w) ? 4'd0 : col_inc[3:0];
      end
    end

    // close on newline, or on end of file with a line still open
    do_close  = newline || (item.end_of_file && open_nxt);
    close_len = newline ? len_r : len_nxt;
    line_inc  = sat_add(line_r, {{(W-1){1'b0}}, 1'b1});
    if (do_close) begin
      line_nxt = line_inc;
      len_nxt  = '0;
      col_nxt  = '0;
      open_nxt = 1'b0;
      if (line_r == '0) begin
        min_len_nxt = close_len;
        min_idx_nxt = line_inc;
        max_len_nxt = close_len;
        max_idx_nxt = line_inc;
      end else begin
        if (close_len < min_len_r) begin
          min_len_nxt = close_len;
          min_idx_nxt = line_inc;
        end
        if (close_len > max_len_r) begin
          max_len_nxt = close_len;
          max_idx_nxt = line_inc;
        end
      end
    end

    result.line_total           = line_nxt;
    result.word_total           = word_nxt;
    result.byte_total           = byte_nxt;
    result.shortest_length      = min_len_nxt;
    result.shortest_line_number = min_idx_nxt;
    result.longest_length       = max_len_nxt;
    result.longest_line_number  = max_idx_nxt;
  end

  // state registers; end of file clears for the next file
  always_ff @(posedge clk) begin
    if (!rst_n || (upd_en && item.end_of_file)) begin
      line_r    <= '0;
      word_r    <= '0;
      byte_r    <= '0;
      len_r     <= '0;
      col_r     <= '0;
      inw_r     <= 1'b0;
      open_r    <= 1'b0;
      min_len_r <= '0;
      min_idx_r <= '0;
      max_len_r <= '0;
      max_idx_r <= '0;
    end else if (upd_en) begin
      line_r    <= line_nxt;
      word_r    <= word_nxt;
      byte_r    <= byte_nxt;
      len_r     <= len_nxt;
      col_r     <= col_nxt;
      inw_r     <= inw_nxt;
      open_r    <= open_nxt;
      min_len_r <= min_len_nxt;
      min_idx_r <= min_idx_nxt;
      max_len_r <= max_len_nxt;
      max_idx_r <= max_idx_nxt;
    end
  end

endmodule

// File: rtl/text_line_word_stats_top.sv
// Top level of the text line and word statistics block.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------
//  in_      | in_valid/in_ready   | in_data   (tlws_pkg::in_word_t)
//  out_     | out_valid/out_ready | out_data  (tlws_pkg::out_word_t)
//  cfg_     | cfg_valid/cfg_ready | cfg_index (1 bit), cfg_data (5 bits)
//
// One byte word is taken per cycle while in_ready is high. A word waits in
// the input register while the statistics update; an end-of-file word then
// loads the result register as it leaves the input register.
// Input stalls only while an end-of-file word waits behind a result that
// out_ready has not taken. Reset (rst_n low, synchronous) clears all counts;
// tab expansion comes up off with a tab stop of 8, and cfg_ready is high.
`timescale 1ns / 1ps

module text_line_word_stats_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tlws_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tlws_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [4:0]          cfg_data
);

  localparam logic [4:0] TAB_WIDTH_RST = 5'd8;

  logic                stage_v_r;
  tlws_pkg::in_word_t  stage_r;
  logic                out_v_r;
  tlws_pkg::out_word_t out_r;
  logic                expand_r;
  logic [4:0]          tabw_r;
  logic                out_free;
  logic                stage_adv;
  tlws_pkg::out_word_t result;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expand_r <= 1'b0;
      tabw_r   <= TAB_WIDTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tlws_pkg::CFG_TAB_EXPAND: expand_r <= cfg_data[0];
        tlws_pkg::CFG_TAB_WIDTH:  tabw_r   <= cfg_data;
        default:                  ;
      endcase
    end
  end

  // handshake: stage moves on unless its result has nowhere to go
  assign out_free  = !out_v_r || out_ready;
  assign stage_adv = stage_v_r && (!stage_r.end_of_file || out_free);
  assign in_ready  = !stage_v_r || stage_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_ready) begin
      stage_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_r <= in_data;
    end
  end

  tlws_stats u_stats (
    .clk           (clk),
    .rst_n         (rst_n),
    .upd_en        (stage_adv),
    .item          (stage_r),
    .tab_expand_en (expand_r),
    .tab_width     (tabw_r),
    .result        (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (stage_adv && stage_r.end_of_file) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_adv && stage_r.end_of_file) begin
      out_r <= result;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  // an end-of-file word that leaves the stage always shows a result next
  a_eof_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_adv && stage_r.end_of_file) |=> out_valid)
    else $error("end of file did not produce a result");

  // input stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (stage_v_r && stage_r.end_of_file && out_v_r && !out_ready))
    else $error("input stalled without a blocked result");

  // a file with no lines reports no line positions
  a_empty_file: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.line_total == '0)) |->
      ((out_data.shortest_line_number == '0) && (out_data.longest_line_number == '0)))
    else $error("line positions set for a file with no lines");

  // shortest never exceeds longest
  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.shortest_length <= out_data.longest_length))
    else $error("shortest length above longest length");
`endif

endmodule
